// ===== design/arq_pkg.sv =====
// Shared constants, codes and types of the selective-repeat ARQ engine.
package arq_pkg;

    localparam int WINDOW_SIZE = 32;
    localparam int SEQ_BITS    = 12;
    localparam int SLOT_BITS   = $clog2(WINDOW_SIZE);
    localparam int OP_W        = 2;
    localparam int SIZE_W      = 16;
    localparam int KIND_W      = 3;
    localparam int RETRY_W     = 2;
    localparam int THR_W       = 8;

    localparam logic [THR_W-1:0]   POLL_THR_DEFAULT = 8'd4;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT      = 2'd3;

    localparam logic [OP_W-1:0] OP_TX     = 2'd0;
    localparam logic [OP_W-1:0] OP_RX     = 2'd1;
    localparam logic [OP_W-1:0] OP_STATUS = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RETX    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SEQ_BITS-1:0] seq_num;
        logic [SIZE_W-1:0]   sdu_size;
        logic                last_in_buffer;
    } in_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SEQ_BITS-1:0] out_seq;
        logic                poll_flag;
        logic [SIZE_W-1:0]   out_size;
        logic [RETRY_W-1:0]  retry_count;
        logic                last_of_run;
    } out_t;

    typedef struct packed {
        logic latch_in;
        logic send_tx;
        logic refuse_tx;
        logic mark_arrival;
        logic emit_ack;
        logic dlv_read;
        logic dlv_emit;
        logic scan_read;
        logic scan_skip;
        logic scan_emit;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            win_full;
        logic            arr_ok;
        logic            run_go;
        logic            dlv_last;
        logic            any_missing;
        logic            scan_hit;
        logic            scan_last;
        logic            out_free;
    } status_t;

endpackage

// ===== design/arq_if.sv =====
// Item channel interfaces for the input and result sides of the ARQ engine.
interface arq_in_if;
    import arq_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SEQ_BITS-1:0] seq_num;
    logic [SIZE_W-1:0]   sdu_size;
    logic                last_in_buffer;

    modport source (output valid, output operation, output seq_num, output sdu_size,
                    output last_in_buffer, input ready);
    modport sink (input valid, input operation, input seq_num, input sdu_size,
                  input last_in_buffer, output ready);
endinterface

interface arq_out_if;
    import arq_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SEQ_BITS-1:0] out_seq;
    logic                poll_flag;
    logic [SIZE_W-1:0]   out_size;
    logic [RETRY_W-1:0]  retry_count;
    logic                last_of_run;

    modport source (output valid, output kind, output out_seq, output poll_flag,
                    output out_size, output retry_count, output last_of_run, input ready);
    modport sink (input valid, input kind, input out_seq, input poll_flag,
                  input out_size, input retry_count, input last_of_run, output ready);
endinterface

// ===== design/arq_ctrl.sv =====
// Controller state machine that sequences transmit, arrival and status items.
module arq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  arq_pkg::status_t status,
    output logic             in_ready,
    output arq_pkg::cmd_t    cmd
);
    import arq_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_DLV_RD    = 3'd2;
    localparam logic [2:0] S_DLV_EMIT  = 3'd3;
    localparam logic [2:0] S_SCAN_RD   = 3'd4;
    localparam logic [2:0] S_SCAN_EMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.op)
                    OP_TX:
                    begin
                        if (status.out_free)
                        begin
                            if (status.win_full)
                            begin
                                cmd.refuse_tx = 1'b1;
                            end
                            else
                            begin
                                cmd.send_tx = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_RX:
                    begin
                        if (status.arr_ok)
                        begin
                            cmd.mark_arrival = 1'b1;
                            state_next       = S_DLV_RD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    OP_STATUS:
                    begin
                        if (status.out_free)
                        begin
                            cmd.emit_ack = 1'b1;
                            state_next   = status.any_missing ? S_SCAN_RD : S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DLV_RD:
            begin
                if (status.run_go)
                begin
                    cmd.dlv_read = 1'b1;
                    state_next   = S_DLV_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DLV_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.dlv_emit = 1'b1;
                    state_next   = status.dlv_last ? S_IDLE : S_DLV_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (status.scan_hit)
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = S_SCAN_EMIT;
                end
                else
                begin
                    cmd.scan_skip = 1'b1;
                end
            end
            S_SCAN_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.scan_emit = 1'b1;
                    state_next    = status.scan_last ? S_IDLE : S_SCAN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/arq_dp.sv =====
// Datapath holding sequence state, the receive bitmap, the PDU stores and the result register.
module arq_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [arq_pkg::THR_W-1:0]  cfg_wr_data,
    input  arq_pkg::in_t               in_data,
    input  arq_pkg::cmd_t              cmd,
    input  logic                       out_ready,
    output logic                       out_valid,
    output arq_pkg::out_t              out_data,
    output arq_pkg::status_t           status
);
    import arq_pkg::*;

    logic [THR_W-1:0]       thr_reg;
    logic [SEQ_BITS-1:0]    tx_reg;
    logic [SEQ_BITS-1:0]    rx_reg;
    logic [THR_W-1:0]       poll_cnt_reg;
    logic [WINDOW_SIZE-1:0] map_reg;
    logic [WINDOW_SIZE-1:0] map_next;
    logic [WINDOW_SIZE-1:0] mask_reg;
    logic [WINDOW_SIZE-1:0] mask_after;
    logic [WINDOW_SIZE-1:0] scan_bit;
    logic [WINDOW_SIZE-1:0] missing;
    logic [SLOT_BITS-1:0]   off_reg;
    logic                   out_valid_reg;
    in_t                    in_reg;
    out_t                   out_reg;
    out_t                   out_next;
    logic                   out_load;
    logic [SIZE_W-1:0]      rd_size_reg;
    logic [RETRY_W-1:0]     rd_retry_reg;
    logic [SIZE_W-1:0]      size_mem [WINDOW_SIZE];
    logic [RETRY_W-1:0]     retry_mem [WINDOW_SIZE];

    logic [SEQ_BITS-1:0]    outstanding;
    logic [SEQ_BITS-1:0]    arr_off;
    logic [SEQ_BITS-1:0]    rx_inc;
    logic [SEQ_BITS-1:0]    scan_sn;
    logic [SLOT_BITS-1:0]   tx_slot;
    logic [SLOT_BITS-1:0]   rx_slot;
    logic [SLOT_BITS-1:0]   rx1_slot;
    logic [SLOT_BITS-1:0]   sn_slot;
    logic [SLOT_BITS-1:0]   scan_slot;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic [THR_W-1:0]       cnt_inc;
    logic                   poll_hit;
    logic [RETRY_W-1:0]     retry_inc;

    assign outstanding = tx_reg - rx_reg;
    assign arr_off     = in_reg.seq_num - rx_reg;
    assign rx_inc      = rx_reg + SEQ_BITS'(1);
    assign scan_sn     = rx_reg + SEQ_BITS'(off_reg);
    assign tx_slot     = tx_reg[SLOT_BITS-1:0];
    assign rx_slot     = rx_reg[SLOT_BITS-1:0];
    assign rx1_slot    = rx_inc[SLOT_BITS-1:0];
    assign sn_slot     = in_reg.seq_num[SLOT_BITS-1:0];
    assign scan_slot   = scan_sn[SLOT_BITS-1:0];
    assign rd_addr     = cmd.scan_read ? scan_slot : rx_slot;
    assign cnt_inc     = poll_cnt_reg + THR_W'(1);
    assign poll_hit    = (cnt_inc >= thr_reg);
    assign retry_inc   = (rd_retry_reg == RETRY_LIMIT) ? rd_retry_reg
                                                       : rd_retry_reg + RETRY_W'(1);

    // A slot is missing when it lies between the receive point and the send point
    // and has not yet arrived.
    always_comb
    begin
        logic [SLOT_BITS-1:0] rel;
        rel = '0;
        for (int s = 0; s < WINDOW_SIZE; s++)
        begin
            rel        = SLOT_BITS'(s) - rx_slot;
            missing[s] = (SEQ_BITS'(rel) < outstanding) && !map_reg[s];
        end
    end

    always_comb
    begin
        scan_bit            = '0;
        scan_bit[scan_slot] = 1'b1;
    end

    assign mask_after = mask_reg & ~scan_bit;

    always_comb
    begin
        map_next = map_reg;
        if (cmd.send_tx)
        begin
            map_next[tx_slot] = 1'b0;
        end
        if (cmd.mark_arrival)
        begin
            map_next[sn_slot] = 1'b1;
        end
        if (cmd.dlv_emit)
        begin
            map_next[rx_slot] = 1'b0;
        end
    end

    assign status.op          = in_reg.operation;
    assign status.win_full    = (outstanding >= SEQ_BITS'(WINDOW_SIZE));
    assign status.arr_ok      = (arr_off < outstanding) && !map_reg[sn_slot];
    assign status.run_go      = (rx_reg != tx_reg) && map_reg[rx_slot];
    assign status.dlv_last    = (rx_inc == tx_reg) || !map_reg[rx1_slot];
    assign status.any_missing = |missing;
    assign status.scan_hit    = mask_reg[scan_slot];
    assign status.scan_last   = (mask_after == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_load = cmd.send_tx || cmd.refuse_tx || cmd.emit_ack
                      || cmd.dlv_emit || cmd.scan_emit;

    always_comb
    begin
        out_next = '0;
        if (cmd.refuse_tx)
        begin
            out_next.kind        = KIND_REFUSED;
            out_next.out_seq     = tx_reg;
            out_next.last_of_run = 1'b1;
        end
        else if (cmd.send_tx)
        begin
            out_next.kind        = KIND_SENT;
            out_next.out_seq     = tx_reg;
            out_next.poll_flag   = poll_hit || in_reg.last_in_buffer;
            out_next.out_size    = in_reg.sdu_size;
            out_next.last_of_run = 1'b1;
        end
        else if (cmd.emit_ack)
        begin
            out_next.kind        = KIND_ACK;
            out_next.out_seq     = rx_reg;
            out_next.last_of_run = !status.any_missing;
        end
        else if (cmd.dlv_emit)
        begin
            out_next.kind        = KIND_DELIVER;
            out_next.out_seq     = rx_reg;
            out_next.out_size    = rd_size_reg;
            out_next.last_of_run = status.dlv_last;
        end
        else if (cmd.scan_emit)
        begin
            out_next.kind        = KIND_RETX;
            out_next.out_seq     = scan_sn;
            out_next.out_size    = rd_size_reg;
            out_next.retry_count = retry_inc;
            out_next.last_of_run = status.scan_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= POLL_THR_DEFAULT;
            tx_reg        <= '0;
            rx_reg        <= '0;
            poll_cnt_reg  <= '0;
            map_reg       <= '0;
            mask_reg      <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.send_tx)
            begin
                tx_reg       <= tx_reg + SEQ_BITS'(1);
                poll_cnt_reg <= poll_hit ? '0 : cnt_inc;
            end
            if (cmd.dlv_emit)
            begin
                rx_reg <= rx_inc;
            end
            map_reg <= map_next;
            if (cmd.emit_ack)
            begin
                mask_reg <= missing;
                off_reg  <= '0;
            end
            else if (cmd.scan_skip)
            begin
                off_reg <= off_reg + SLOT_BITS'(1);
            end
            else if (cmd.scan_emit)
            begin
                off_reg  <= off_reg + SLOT_BITS'(1);
                mask_reg <= mask_after;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_reg <= in_data;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (cmd.send_tx)
        begin
            size_mem[tx_slot]  <= in_reg.sdu_size;
            retry_mem[tx_slot] <= '0;
        end
        else if (cmd.scan_emit)
        begin
            retry_mem[scan_slot] <= retry_inc;
        end
        if (cmd.dlv_read || cmd.scan_read)
        begin
            rd_size_reg  <= size_mem[rd_addr];
            rd_retry_reg <= retry_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/arq_sender_receiver_engine_unit.sv =====
// Top level of the selective-repeat ARQ engine with poll counter and reordering receiver.
// One item at a time: an accepted item is decoded in the next cycle, and a transmit, refusal or
// status ack is loaded into the result register from the decode state once that register is free.
// Each delivery and each retransmission is a store read followed by a result load, and the
// status scan also steps over each arrived offset ahead of the last missing one.
// A new item is accepted after the last result of the previous one is loaded; reset clears the
// sequence numbers, poll counter and receive bitmap, and sets the threshold to 4.
module arq_sender_receiver_engine_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [arq_pkg::THR_W-1:0] cfg_wr_data,
    arq_in_if.sink                    in_item,
    arq_out_if.source                 out_item
);
    import arq_pkg::*;

    cmd_t    cmd;
    status_t status;
    in_t     in_data;
    out_t    out_data;
    logic    ctrl_in_ready;
    logic    dp_out_valid;

    assign in_data.operation      = in_item.operation;
    assign in_data.seq_num        = in_item.seq_num;
    assign in_data.sdu_size       = in_item.sdu_size;
    assign in_data.last_in_buffer = in_item.last_in_buffer;
    assign in_item.ready          = ctrl_in_ready;

    arq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .status   (status),
        .in_ready (ctrl_in_ready),
        .cmd      (cmd)
    );

    arq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .out_ready   (out_item.ready),
        .out_valid   (dp_out_valid),
        .out_data    (out_data),
        .status      (status)
    );

    assign out_item.valid       = dp_out_valid;
    assign out_item.kind        = out_data.kind;
    assign out_item.out_seq     = out_data.out_seq;
    assign out_item.poll_flag   = out_data.poll_flag;
    assign out_item.out_size    = out_data.out_size;
    assign out_item.retry_count = out_data.retry_count;
    assign out_item.last_of_run = out_data.last_of_run;

    a_emit_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.send_tx || cmd.refuse_tx || cmd.emit_ack || cmd.dlv_emit || cmd.scan_emit)
        |-> status.out_free)
        else $error("result loaded while the result register was still occupied");

    a_one_result_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.send_tx, cmd.refuse_tx, cmd.emit_ack, cmd.dlv_emit, cmd.scan_emit}))
        else $error("more than one result produced in a cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_item.valid && in_item.ready) |=> !in_item.ready)
        else $error("new item accepted while the previous one is in progress");

    a_single_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && (out_item.kind == KIND_SENT || out_item.kind == KIND_REFUSED))
        |-> out_item.last_of_run)
        else $error("transmit result not marked as last of its run");

endmodule

// ===== tb/arq_tb_pkg.sv =====
// Result tracker for the ARQ engine testbench: predicts every result item and checks it on arrival.
`timescale 1ns / 1ps
package arq_tb_pkg;
    import arq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int REPORT_LIMIT = 10;

    class arq_result_tracker;
        logic [THR_W-1:0]    poll_threshold;
        logic [THR_W-1:0]    poll_count;
        logic [SEQ_BITS-1:0] tx_next;
        logic [SEQ_BITS-1:0] rx_next;
        bit                  arrived [WINDOW_SIZE];
        logic [SIZE_W-1:0]   stored_size [WINDOW_SIZE];
        logic [RETRY_W-1:0]  stored_retry [WINDOW_SIZE];
        out_t                awaited_results [$];
        int                  failures;
        int                  items_noted;
        int                  results_checked;
        int                  kind_seen [5];

        function new();
            poll_threshold = POLL_THR_DEFAULT;
            poll_count = '0;
            tx_next = '0;
            rx_next = '0;
            foreach (arrived[i])
            begin
                arrived[i] = 1'b0;
                stored_size[i] = '0;
                stored_retry[i] = '0;
            end
            failures = 0;
            items_noted = 0;
            results_checked = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
        endfunction

        function out_t make_result(logic [KIND_W-1:0] kind, logic [SEQ_BITS-1:0] sn,
                                   logic poll, logic [SIZE_W-1:0] size,
                                   logic [RETRY_W-1:0] retry);
            out_t res;
            res.kind = kind;
            res.out_seq = sn;
            res.poll_flag = poll;
            res.out_size = size;
            res.retry_count = retry;
            res.last_of_run = 1'b0;
            return res;
        endfunction

        function string describe(out_t r);
            return $sformatf("kind %0d seq %0d poll %0b size %0d retry %0d last %0b",
                             r.kind, r.out_seq, r.poll_flag, r.out_size, r.retry_count,
                             r.last_of_run);
        endfunction

        // Works out the results of one accepted item and updates the link state.
        function void note_item(in_t item);
            logic [SLOT_BITS-1:0] slot;
            logic [SEQ_BITS-1:0]  flight;
            logic [SEQ_BITS-1:0]  offset;
            logic [SEQ_BITS-1:0]  sn;
            logic                 poll;
            out_t                 run [$];
            items_noted++;
            flight = tx_next - rx_next;
            case (item.operation)
                OP_TX:
                begin
                    if (flight >= WINDOW_SIZE)
                    begin
                        run.insert(run.size(), make_result(KIND_REFUSED, tx_next, 1'b0,
                                                           '0, '0));
                    end
                    else
                    begin
                        slot = tx_next[SLOT_BITS-1:0];
                        poll = 1'b0;
                        poll_count = poll_count + 1'b1;
                        if (poll_count >= poll_threshold)
                        begin
                            poll = 1'b1;
                            poll_count = '0;
                        end
                        if (item.last_in_buffer)
                            poll = 1'b1;
                        stored_size[slot] = item.sdu_size;
                        stored_retry[slot] = '0;
                        arrived[slot] = 1'b0;
                        run.insert(run.size(), make_result(KIND_SENT, tx_next, poll,
                                                           item.sdu_size, '0));
                        tx_next = tx_next + 1'b1;
                    end
                end
                OP_RX:
                begin
                    offset = item.seq_num - rx_next;
                    slot = item.seq_num[SLOT_BITS-1:0];
                    if (offset < flight && !arrived[slot])
                    begin
                        arrived[slot] = 1'b1;
                        while (rx_next != tx_next && arrived[rx_next[SLOT_BITS-1:0]])
                        begin
                            slot = rx_next[SLOT_BITS-1:0];
                            arrived[slot] = 1'b0;
                            run.insert(run.size(), make_result(KIND_DELIVER, rx_next, 1'b0,
                                                               stored_size[slot], '0));
                            rx_next = rx_next + 1'b1;
                        end
                    end
                end
                OP_STATUS:
                begin
                    run.insert(run.size(), make_result(KIND_ACK, rx_next, 1'b0, '0, '0));
                    for (int i = 0; i < flight && i < WINDOW_SIZE; i++)
                    begin
                        sn = rx_next + i[SEQ_BITS-1:0];
                        slot = sn[SLOT_BITS-1:0];
                        if (!arrived[slot])
                        begin
                            if (stored_retry[slot] != RETRY_LIMIT)
                                stored_retry[slot] = stored_retry[slot] + 1'b1;
                            run.insert(run.size(), make_result(KIND_RETX, sn, 1'b0,
                                                               stored_size[slot],
                                                               stored_retry[slot]));
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (run.size() > 0)
                run[run.size()-1].last_of_run = 1'b1;
            foreach (run[i])
                awaited_results.insert(awaited_results.size(), run[i]);
        endfunction

        function void check_result(out_t got);
            out_t want;
            results_checked++;
            if (got.kind <= KIND_REFUSED)
                kind_seen[got.kind]++;
            if (awaited_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Unexpected result: expected none, got %s", describe(got));
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.out_seq !== want.out_seq ||
                got.poll_flag !== want.poll_flag || got.out_size !== want.out_size ||
                got.retry_count !== want.retry_count || got.last_of_run !== want.last_of_run)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Result %0d wrong: expected %s, got %s", results_checked,
                             describe(want), describe(got));
            end
        endfunction
    endclass

endpackage

// ===== tb/testbench.sv =====
// Top level of the ARQ engine testbench: clock, reset, item drivers, result sink and watchdog.
`timescale 1ns / 1ps
module testbench;
    import arq_pkg::*;
    import arq_tb_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TIME  = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 25;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [THR_W-1:0]  cfg_wr_data;
    bit                calm_phase;
    int                quiet_cycles;
    arq_result_tracker tracker;

    arq_in_if  in_item ();
    arq_out_if out_item ();

    arq_sender_receiver_engine_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_item),
        .out_item    (out_item)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SEQ_BITS-1:0] sn,
                             input logic [SIZE_W-1:0] size, input logic last);
        int   gap;
        in_t  item;
        gap = calm_phase ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_item.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.operation = op;
        in_item.seq_num = sn;
        in_item.sdu_size = size;
        in_item.last_in_buffer = last;
        in_item.valid = 1'b1;
        do @(posedge clk); while (in_item.ready !== 1'b1);
        item.operation = op;
        item.seq_num = sn;
        item.sdu_size = size;
        item.last_in_buffer = last;
        tracker.note_item(item);
        @(negedge clk);
    endtask

    // The engine may still be marking an arrival that produced no result, so allow it to settle.
    task automatic wait_for_idle();
        in_item.valid = 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_wr_data = value;
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        tracker.poll_threshold = value;
    endtask

    initial
    begin
        int                  stall;
        out_t                got;
        out_item.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm_phase ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_item.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_item.ready = 1'b1;
            do @(posedge clk); while (out_item.valid !== 1'b1);
            got.kind = out_item.kind;
            got.out_seq = out_item.out_seq;
            got.poll_flag = out_item.poll_flag;
            got.out_size = out_item.out_size;
            got.retry_count = out_item.retry_count;
            got.last_of_run = out_item.last_of_run;
            tracker.check_result(got);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_item.valid && in_item.ready) ||
            (out_item.valid && out_item.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a handshake.", quiet_cycles);
            $display("arq_sender_receiver_engine_unit test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int                  count;
        int                  pick;
        int                  tx_cut;
        int                  rx_cut;
        int                  noise_cut;
        int                  status_cut;
        logic [OP_W-1:0]     op;
        logic [SEQ_BITS-1:0] sn;
        logic [SEQ_BITS-1:0] flight;
        logic [SIZE_W-1:0]   size;
        logic                last;
        logic [THR_W-1:0]    thresholds [PHASES];
        tracker = new();
        quiet_cycles = 0;
        calm_phase = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_item.valid = 1'b0;
        in_item.operation = OP_TX;
        in_item.seq_num = '0;
        in_item.sdu_size = '0;
        in_item.last_in_buffer = 1'b0;
        thresholds = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd1, 8'd255, 8'd3, 8'd7};
        thresholds[6] = THR_W'($urandom_range(3, 254));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset threshold.
        send_item(OP_STATUS, 12'd0, 16'd0, 1'b0);
        send_item(OP_UNUSED, 12'd5, 16'd9, 1'b1);
        send_item(OP_RX, 12'd4095, 16'd0, 1'b0);
        send_item(OP_TX, 12'd0, 16'd0, 1'b0);
        send_item(OP_TX, 12'd4095, 16'hFFFF, 1'b1);
        send_item(OP_TX, 12'd0, 16'h1234, 1'b0);
        send_item(OP_TX, 12'd0, 16'hA5A5, 1'b0);
        send_item(OP_RX, 12'd2, 16'd0, 1'b0);
        send_item(OP_RX, 12'd2, 16'd0, 1'b0);
        repeat (4) send_item(OP_STATUS, 12'd0, 16'd0, 1'b0);
        send_item(OP_RX, 12'd0, 16'd0, 1'b0);
        send_item(OP_RX, 12'd1, 16'hFFFF, 1'b1);
        send_item(OP_RX, 12'd3, 16'd0, 1'b0);
        send_item(OP_RX, 12'd3, 16'd0, 1'b0);
        send_item(OP_STATUS, 12'hFFF, 16'hFFFF, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_idle();
            write_threshold(thresholds[phase]);
            calm_phase = (phase % 4 == 3);
            if (phase % 3 == 1)
            begin
                tx_cut = 75;
                rx_cut = 93;
                noise_cut = 96;
                status_cut = 99;
            end
            else
            begin
                tx_cut = 40;
                rx_cut = 75;
                noise_cut = 85;
                status_cut = 95;
            end
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                flight = tracker.tx_next - tracker.rx_next;
                sn = SEQ_BITS'($urandom);
                size = SIZE_W'($urandom);
                last = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 7) == 0)
                    size = $urandom_range(0, 1) ? '1 : '0;
                if (pick < tx_cut || (pick < rx_cut && flight == 0))
                begin
                    op = OP_TX;
                end
                else if (pick < rx_cut)
                begin
                    op = OP_RX;
                    sn = tracker.rx_next + SEQ_BITS'($urandom_range(0, flight - 1));
                end
                else if (pick < noise_cut)
                begin
                    op = OP_RX;
                end
                else if (pick < status_cut)
                begin
                    op = OP_STATUS;
                end
                else
                begin
                    op = OP_UNUSED;
                end
                send_item(op, sn, size, last);
                if (op != OP_UNUSED)
                    count++;
            end
        end

        in_item.valid = 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);
        if (tracker.awaited_results.size() != 0)
            tracker.failures++;
        $display("Run covered %0d input items over %0d poll threshold settings.",
                 tracker.items_noted, PHASES + 1);
        $display("Checked %0d results: %0d sent, %0d delivered, %0d acks, %0d resent, %0d refused.",
                 tracker.results_checked, tracker.kind_seen[KIND_SENT],
                 tracker.kind_seen[KIND_DELIVER], tracker.kind_seen[KIND_ACK],
                 tracker.kind_seen[KIND_RETX], tracker.kind_seen[KIND_REFUSED]);
        if (tracker.failures == 0)
            $display("arq_sender_receiver_engine_unit test passed");
        else
            $display("arq_sender_receiver_engine_unit test failed");
        $finish;
    end

endmodule
